// ===== hw/rtl/jlcg_pkg.sv =====
// ----------------------------------------------------------------------------
// jlcg_pkg
// Shared constants, opcodes and controller/datapath interface types for the
// 48-bit linear congruential random source.
// ----------------------------------------------------------------------------
`default_nettype none
package jlcg_pkg;

  localparam int unsigned StateW = 48;
  localparam logic [StateW-1:0] LcgMult  = 48'h0005_DEEC_E66D;
  localparam logic [StateW-1:0] LcgAdd   = 48'h0000_0000_000B;
  localparam logic [StateW-1:0] LcgScram = 48'h0005_DEEC_E66D;

  // operation codes
  localparam logic [2:0] FuncReseed = 3'd0;
  localparam logic [2:0] FuncBits   = 3'd1;
  localparam logic [2:0] FuncBound  = 3'd2;
  localparam logic [2:0] FuncLong   = 3'd3;
  localparam logic [2:0] FuncBool   = 3'd4;

  // datapath commands
  typedef enum logic [2:0] {
    CMD_NONE   = 3'd0,
    CMD_LOAD   = 3'd1,  // capture input operands
    CMD_RESEED = 3'd2,  // load state from seed
    CMD_MUL_LO = 3'd3,  // state low half product
    CMD_MUL_HI = 3'd4,  // finish advance
    CMD_DIV    = 3'd5,  // one restoring division step
    CMD_FINISH = 3'd6,  // form result
    CMD_SAVEHI = 3'd7   // keep first long draw
  } jlcg_op_t;

  typedef enum logic [2:0] {
    RES_ZERO  = 3'd0,
    RES_BITS  = 3'd1,
    RES_POW2  = 3'd2,
    RES_REM   = 3'd3,
    RES_LONG  = 3'd4,
    RES_ERROR = 3'd5,
    RES_BOOL  = 3'd6
  } jlcg_res_t;

  typedef struct packed {
    jlcg_op_t  op;
    jlcg_res_t res;
    logic      div_init;
  } jlcg_cmd_t;

  typedef struct packed {
    logic [2:0] func;
    logic       bad_bound;
    logic       pow2;
    logic       div_done;
    logic       reject;
  } jlcg_sts_t;

endpackage
`default_nettype wire

// ===== hw/rtl/jlcg_datapath.sv =====
// ----------------------------------------------------------------------------
// jlcg_datapath
// State register, low/high-step LCG advance using a split 24-bit multiply, a
// bit-serial 31-bit divider for the rejection loop and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
module jlcg_datapath
  import jlcg_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic [2:0]        in_func,
  input  wire logic [5:0]        in_bit_count,
  input  wire logic [31:0]       in_bound,
  input  wire logic [63:0]       in_seed_value,
  input  wire jlcg_cmd_t         cmd,
  output jlcg_sts_t              sts,
  output logic [63:0]            res_value,
  output logic                   res_error
);

  logic [StateW-1:0] state_r, state_nxt;
  logic [2:0]  func_r;
  logic [5:0]  cnt_r;
  logic [31:0] bound_r;
  logic [63:0] seed_r;
  logic [47:0] plo_r;
  logic [31:0] hi_r;
  logic [30:0] quo_r;   // dividend bits shifted out
  logic [31:0] rem_r;
  logic [4:0]  dstep_r;
  logic [63:0] value_r;
  logic        error_r;

  // advance split: s*M = slo*M + (shi*M)<<24 mod 2^48
  logic [47:0] prod_lo, prod_hi;
  assign prod_lo = {24'd0, state_r[23:0]} * LcgMult;
  assign prod_hi = {24'd0, state_r[47:24]} * LcgMult;

  // draws from the current state
  logic [5:0]  cnt_sat;
  logic [31:0] draw_n, draw31, draw32;
  logic [63:0] shifted;
  assign cnt_sat = (cnt_r > 6'd32) ? 6'd32 : cnt_r;
  assign shifted = {16'd0, state_r} >> (6'd48 - cnt_sat);
  assign draw_n  = shifted[31:0];
  assign draw31  = {1'b0, state_r[47:17]};
  assign draw32  = state_r[47:16];

  // one restoring division step
  logic [31:0] rem_sh;
  logic        ge;
  assign rem_sh = {rem_r[30:0], quo_r[30]};
  assign ge     = rem_sh >= bound_r;

  logic [31:0] chk;
  assign chk = draw31 - rem_r + (bound_r - 32'd1);

  logic [63:0] pow2_prod;
  assign pow2_prod = {32'd0, bound_r} * {32'd0, draw31};

  // datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= LcgScram;
    end else begin
      state_r <= state_nxt;
    end
    unique case (cmd.op)
      CMD_LOAD: begin
        func_r  <= in_func;
        cnt_r   <= in_bit_count;
        bound_r <= in_bound;
        seed_r  <= in_seed_value;
      end
      CMD_MUL_LO: plo_r <= prod_lo;
      CMD_SAVEHI: hi_r  <= draw32;
      CMD_DIV: begin
        if (cmd.div_init) begin
          quo_r   <= draw31[30:0];
          rem_r   <= 32'd0;
          dstep_r <= 5'd0;
        end else begin
          quo_r   <= {quo_r[29:0], 1'b0};
          rem_r   <= ge ? rem_sh - bound_r : rem_sh;
          dstep_r <= dstep_r + 5'd1;
        end
      end
      CMD_FINISH: begin
        error_r <= (cmd.res == RES_ERROR);
        case (cmd.res)
          RES_BITS: value_r <= (cnt_r == 6'd0) ? 64'd0 : {{32{draw_n[31]}}, draw_n};
          RES_POW2: value_r <= {{32{pow2_prod[62]}}, pow2_prod[62:31]};
          RES_REM:  value_r <= {32'd0, rem_r};
          RES_LONG: value_r <= {hi_r, 32'd0} + {{32{draw32[31]}}, draw32};
          RES_BOOL: value_r <= {63'd0, state_r[47]};
          default:  value_r <= 64'd0;
        endcase
      end
      default: ;
    endcase
  end

  // state next value
  always_comb begin
    state_nxt = state_r;
    unique case (cmd.op)
      CMD_RESEED: state_nxt = seed_r[47:0] ^ LcgScram;
      CMD_MUL_HI: state_nxt = plo_r + {prod_hi[23:0], 24'd0} + LcgAdd;
      default: ;
    endcase
  end

  // status to controller
  assign sts.func      = func_r;
  assign sts.bad_bound = (bound_r == 32'd0) || bound_r[31];
  assign sts.pow2      = ((bound_r & (bound_r - 32'd1)) == 32'd0);
  assign sts.div_done  = (dstep_r == 5'd30);
  assign sts.reject    = chk[31];
  assign res_value     = value_r;
  assign res_error     = error_r;

endmodule
`default_nettype wire

// ===== hw/rtl/jlcg_ctrl.sv =====
// ----------------------------------------------------------------------------
// jlcg_ctrl
// Sequencer: accepts a transaction, steps the datapath through advances,
// division and result forming, and holds the result until taken.
// ----------------------------------------------------------------------------
`default_nettype none
module jlcg_ctrl
  import jlcg_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  wire logic      out_ready,
  input  wire jlcg_sts_t sts,
  output jlcg_cmd_t      cmd
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_DEC   = 9'b000000010,
    S_MLO   = 9'b000000100,
    S_MHI   = 9'b000001000,
    S_DINIT = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_CHK   = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   second_r, second_nxt;  // long: second draw pending

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  // result selection by operation
  jlcg_res_t res_sel;
  always_comb begin
    case (sts.func)
      FuncBits:  res_sel = RES_BITS;
      FuncBound: res_sel = sts.bad_bound ? RES_ERROR : (sts.pow2 ? RES_POW2 : RES_REM);
      FuncLong:  res_sel = RES_LONG;
      FuncBool:  res_sel = RES_BOOL;
      default:   res_sel = RES_ZERO;
    endcase
  end

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    second_nxt   = second_r;
    cmd.op       = CMD_NONE;
    cmd.res      = res_sel;
    cmd.div_init = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          second_nxt = 1'b0;
          state_nxt  = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.func == FuncReseed) begin
          cmd.op    = CMD_RESEED;
          state_nxt = S_FIN;
        end else if ((sts.func == FuncBound && !sts.bad_bound) || sts.func == FuncBits
                     || sts.func == FuncLong || sts.func == FuncBool) begin
          state_nxt = S_MLO;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MLO: begin
        cmd.op    = CMD_MUL_LO;
        state_nxt = S_MHI;
      end
      S_MHI: begin
        cmd.op = CMD_MUL_HI;
        if (sts.func == FuncLong && !second_r) begin
          state_nxt = S_FIN;
        end else if (sts.func == FuncBound && !sts.pow2) begin
          state_nxt = S_DINIT;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_DINIT: begin
        cmd.op       = CMD_DIV;
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.op = CMD_DIV;
        if (sts.div_done) state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = sts.reject ? S_MLO : S_FIN;
      end
      S_FIN: begin
        if (sts.func == FuncLong && !second_r) begin
          cmd.op     = CMD_SAVEHI;
          second_nxt = 1'b1;
          state_nxt  = S_MLO;
        end else begin
          cmd.op    = CMD_FINISH;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      second_r <= second_nxt;
    end
  end

  // checks
  a_ready_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready and result valid together");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV && sts.div_done |=> state_r == S_CHK) else $error("divider overrun");
  a_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_DEC) else $error("accept lost");

endmodule
`default_nettype wire

// ===== hw/rtl/java_lcg_random_source_core.sv =====
// ----------------------------------------------------------------------------
// java_lcg_random_source_core
// 48-bit linear congruential random source with reseed, n-bit, bounded,
// long and boolean draws; one result per transaction.
// ----------------------------------------------------------------------------
// reseed/no-op/error need no LCG advance; n-bit, bounded and boolean draws take
// one advance, long two; a non-power-of-two bound runs a 31-step serial divider per redraw
// one transaction in flight; next accepted the cycle after the result is taken
// each LCG advance is a low and a high step through a 24x48 multiplier
// synchronous active-low reset loads the scrambled zero seed
`default_nettype none
module java_lcg_random_source_core
  import jlcg_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_func,
  input  wire logic [5:0]  in_bit_count,
  input  wire logic [31:0] in_bound,
  input  wire logic [63:0] in_seed_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [63:0]      out_value,
  output logic             out_error
);

  jlcg_cmd_t cmd;
  jlcg_sts_t sts;

  // sequencer
  jlcg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath
  jlcg_datapath u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_func       (in_func),
    .in_bit_count  (in_bit_count),
    .in_bound      (in_bound),
    .in_seed_value (in_seed_value),
    .cmd           (cmd),
    .sts           (sts),
    .res_value     (out_value),
    .res_error     (out_error)
  );

endmodule
`default_nettype wire

// ===== tb/sv/java_lcg_random_source_core_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// java_lcg_random_source_core_test
// Drives reseed, n-bit, bounded, long and boolean draws into the random
// source and checks every result against an in-bench 48-bit LCG predictor.
// ----------------------------------------------------------------------------
module java_lcg_random_source_core_test;
  import jlcg_pkg::*;

  typedef struct packed {
    logic [63:0] value;
    logic        error;
  } draw_res_t;

  // scoreboard: lcg predictor plus queue of expected draws
  class lcg_scoreboard;
    logic [47:0] lcg;
    draw_res_t   pending[$];
    int          errors;

    function new();
      lcg = LcgScram;
      errors = 0;
    endfunction

    function logic [31:0] take_bits(int n);
      lcg = lcg * LcgMult + LcgAdd;
      return 32'(lcg >> (48 - n));
    endfunction

    task report_mismatch(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    function void note_input(logic [2:0] func, logic [5:0] cnt, logic [31:0] bnd,
                             logic [63:0] seed);
      draw_res_t   r;
      logic [31:0] d, m, hi;
      logic [63:0] prod;
      int          n;
      r = '0;
      case (func)
        FuncReseed: lcg = seed[47:0] ^ LcgScram;
        FuncBits: begin
          if (cnt == 0) begin
            void'(take_bits(1));
          end else begin
            n = (cnt > 32) ? 32 : cnt;
            r.value = {{32{1'b0}}, take_bits(n)};
            r.value = {{32{r.value[31]}}, r.value[31:0]};
          end
        end
        FuncBound: begin
          if (bnd == 0 || bnd[31]) begin
            r.error = 1'b1;
          end else if ((bnd & (bnd - 1)) == 0) begin
            prod = {32'd0, bnd} * {32'd0, take_bits(31)};
            d = prod[62:31];
            r.value = {{32{d[31]}}, d};
          end else begin
            do begin
              d = take_bits(31);
              m = d % bnd;
            end while (((d - m + (bnd - 1)) & 32'h8000_0000) != 0);
            r.value = {32'd0, m};
          end
        end
        FuncLong: begin
          hi = take_bits(32);
          d = take_bits(32);
          r.value = {hi, 32'd0} + {{32{d[31]}}, d};
        end
        FuncBool: begin
          d = take_bits(1);
          r.value = {63'd0, d[0]};
        end
        default: ;
      endcase
      pending.push_back(r);
    endfunction

    task check_result(logic [63:0] value, logic error);
      draw_res_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (value !== e.value) report_mismatch($sformatf("value %h, expected %h", value, e.value));
      if (error !== e.error) report_mismatch($sformatf("error %b, expected %b", error, e.error));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  in_func = '0;
  logic [5:0]  in_bit_count = '0;
  logic [31:0] in_bound = '0;
  logic [63:0] in_seed_value = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [63:0] out_value;
  logic        out_error;

  int unsigned send_idle = 0;
  int unsigned recv_idle = 0;
  bit          hold_off = 1'b0;
  int unsigned quiet_cycles = 0;
  lcg_scoreboard sb;

  java_lcg_random_source_core dut (.*);

  always #4 clk = ~clk;

  // result side: check and randomly stall
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_result(out_value, out_error);
    out_ready <= !hold_off && ($urandom_range(99) >= recv_idle);
  end

  // watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // send one transaction, with random gap beforehand
  task automatic send_op(logic [2:0] f, logic [5:0] c, logic [31:0] b, logic [63:0] s);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_func <= f;
    in_bit_count <= c;
    in_bound <= b;
    in_seed_value <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(f, c, b, s);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  task automatic random_op();
    logic [2:0]  f;
    logic [31:0] b;
    int          k;
    f = 3'($urandom_range(7));
    if (f > 4 && $urandom_range(3) != 0) f = FuncBits;
    k = $urandom_range(9);
    if (k < 3) b = 32'd1 << $urandom_range(30);
    else if (k < 5) b = $urandom_range(1000, 1);
    else b = $urandom;
    send_op(f, 6'($urandom_range(63)), b, {$urandom, $urandom});
  endtask

  initial begin
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: every operation and the corner cases
    send_op(FuncBits, 6'd1, '0, '0);
    send_op(FuncBits, 6'd32, '0, '0);
    send_op(FuncBits, 6'd0, '0, '0);
    send_op(FuncBits, 6'd63, '0, '0);
    send_op(FuncBits, 6'd33, '0, '0);
    send_op(FuncBound, 6'd0, 32'd0, '0);
    send_op(FuncBound, 6'd0, 32'h8000_0000, '0);
    send_op(FuncBound, 6'd0, 32'hFFFF_FFFF, '0);
    send_op(FuncBound, 6'd0, 32'd1, '0);
    send_op(FuncBound, 6'd0, 32'h4000_0000, '0);
    send_op(FuncBound, 6'd0, 32'h7FFF_FFFF, '0);
    send_op(FuncBound, 6'd0, 32'h6000_0001, '0);
    send_op(FuncBound, 6'd0, 32'd3, '0);
    send_op(FuncLong, 6'd0, '0, '0);
    send_op(FuncBool, 6'd0, '0, '0);
    send_op(3'd5, 6'd0, '0, '0);
    send_op(3'd7, 6'h3F, 32'hFFFF_FFFF, '1);
    send_op(FuncReseed, 6'd0, '0, 64'h7FFF_FFFF_FFFF_FFFF);
    send_op(FuncLong, 6'd0, '0, '0);
    send_op(FuncReseed, 6'd0, '0, 64'h8000_0000_0000_0000);
    send_op(FuncBits, 6'd32, '0, '0);
    send_op(FuncReseed, 6'd0, '0, '1);
    send_op(FuncBound, 6'd0, 32'd1000, '0);

    // long receiver hold-off while input backs up
    fork
      begin
        hold_off = 1'b1;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      repeat (4) random_op();
    join
    drain();

    // random phases with changing idle mix
    send_idle = 35; recv_idle = 85;
    repeat (630) begin
      if ($urandom_range(20) == 0) send_op(FuncReseed, '0, '0, {$urandom, $urandom});
      else random_op();
    end
    drain();
    send_idle = 85; recv_idle = 35;
    repeat (630) random_op();
    send_idle = 0; recv_idle = 0;
    repeat (630) random_op();

    drain();
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
